FILE: rtl/cv_scale_quantizer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pitch CV quantiser
// Shared property forms, clocked on clk and idle while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CV_SCALE_QUANTIZER_TOP_MACROS_SVH
`define CV_SCALE_QUANTIZER_TOP_MACROS_SVH

// Same-cycle implication
`define CVSQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CVSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cvsq_pkg.sv
// ----------------------------------------------------------------------------
// cvsq_pkg
// Widths, constants, register indexes and stage records of the CV quantiser.
// ----------------------------------------------------------------------------
`default_nettype none

package cvsq_pkg;

    localparam int MAX_NOTES      = 16;
    localparam int UNITS_PER_VOLT = 1536;
    localparam int NOTE_W         = 16;
    localparam int IDX_W          = 4;
    localparam int PAIRS          = MAX_NOTES - 1;
    localparam int RAW_W          = 15;
    localparam int OCT_W          = 5;
    localparam int FRAC_W         = 11;
    localparam int QCV_W          = 16;
    localparam int COUNT_W        = 5;
    localparam int WORD_W         = 64;
    localparam int NOTES_PER_WORD = 4;
    localparam int CFG_INDEX_W    = 3;
    localparam int SUM_W          = 18;

    typedef logic [MAX_NOTES-1:0][NOTE_W-1:0] notes_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NOTE_COUNT = 3'd0,
        REG_NOTES_A    = 3'd1,
        REG_NOTES_B    = 3'd2,
        REG_NOTES_C    = 3'd3,
        REG_NOTES_D    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [RAW_W-1:0]  raw;
        logic signed [OCT_W-1:0]  oct;
        logic        [FRAC_W-1:0] frac;
    } split_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw;
        logic signed [OCT_W-1:0] oct;
        logic        [PAIRS-1:0] hit;
        logic        [PAIRS-1:0] up;
        logic                    below;
        logic                    prev_first;
        logic                    next_first;
        logic                    pass;
        logic        [IDX_W-1:0] last_idx;
    } cmp_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw;
        logic signed [OCT_W-1:0] oct;
        logic        [IDX_W-1:0] idx;
        logic                    pass;
    } sel_t;

endpackage

`default_nettype wire

FILE: rtl/cvsq_split.sv
// ----------------------------------------------------------------------------
// cvsq_split
// First stage: floored octave and fraction within the octave.
// ----------------------------------------------------------------------------
`default_nettype none

module cvsq_split (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  valid_in,
    input  wire logic signed [cvsq_pkg::RAW_W-1:0]     raw_in,
    output logic                                       up_ready,
    input  wire logic                                  down_ready,
    output logic                                       valid_out,
    output cvsq_pkg::split_t                           data_out
);
    import cvsq_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    split_t      data_reg;
    split_t      data_next;
    logic [5:0]  volt_q;
    logic [6:0]  shifted;
    logic [11:0] prod;
    logic [OCT_W-1:0]  oct_c;
    logic [16:0] raw_ext;
    logic [16:0] oct_scaled;
    logic [16:0] diff;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        // floor(v / 1536) = floor(floor(v / 512) / 3)
        volt_q     = raw_in[RAW_W-1:9];
        shifted    = {volt_q[5], volt_q} + 7'd33;
        prod       = {5'b0, shifted} * 12'd43;
        oct_c      = prod[11:7] - 5'd11;
        raw_ext    = {{2{raw_in[RAW_W-1]}}, raw_in};
        oct_scaled = {{12{oct_c[OCT_W-1]}}, oct_c} * 17'(UNITS_PER_VOLT);
        diff       = raw_ext - oct_scaled;
        data_next.raw  = raw_in;
        data_next.oct  = oct_c;
        data_next.frac = diff[FRAC_W-1:0];
        valid_next = up_ready ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/cvsq_compare.sv
// ----------------------------------------------------------------------------
// cvsq_compare
// Second stage: parallel note-pair compares and wrap-around decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module cvsq_compare (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [cvsq_pkg::COUNT_W-1:0]      note_count,
    input  wire cvsq_pkg::notes_t                  notes,
    input  wire logic                              valid_in,
    input  wire cvsq_pkg::split_t                  data_in,
    output logic                                   up_ready,
    input  wire logic                              down_ready,
    output logic                                   valid_out,
    output cvsq_pkg::cmp_t                         data_out
);
    import cvsq_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    cmp_t               data_reg;
    cmp_t               data_next;
    logic [COUNT_W-1:0] n_eff;
    logic [NOTE_W-1:0]  frac_ext;
    logic [NOTE_W-1:0]  first;
    logic [NOTE_W-1:0]  last;
    logic [SUM_W-1:0]   pair_sum;
    logic [SUM_W-1:0]   twice_frac;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        n_eff = (note_count > COUNT_W'(MAX_NOTES)) ? COUNT_W'(MAX_NOTES) : note_count;
        frac_ext = {{(NOTE_W-FRAC_W){1'b0}}, data_in.frac};
        data_next.raw  = data_in.raw;
        data_next.oct  = data_in.oct;
        data_next.pass = (n_eff == '0);
        data_next.last_idx = (n_eff == '0) ? '0 : IDX_W'(n_eff - 1'b1);
        for (int i = 0; i < PAIRS; i++)
        begin
            data_next.hit[i] = (n_eff > COUNT_W'(i + 1))
                               && (frac_ext >= notes[i]) && (frac_ext <= notes[i+1]);
            data_next.up[i]  = ({1'b0, notes[i+1]} + {1'b0, notes[i]})
                               < {frac_ext, 1'b0};
        end
        first      = notes[0];
        last       = notes[data_next.last_idx];
        pair_sum   = {2'b0, first} + {2'b0, last};
        twice_frac = {{(SUM_W-FRAC_W-1){1'b0}}, data_in.frac, 1'b0};
        data_next.below      = frac_ext < first;
        data_next.prev_first = pair_sum < (twice_frac + SUM_W'(UNITS_PER_VOLT));
        data_next.next_first = (pair_sum + SUM_W'(UNITS_PER_VOLT)) < twice_frac;
        valid_next = up_ready ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/cvsq_select.sv
// ----------------------------------------------------------------------------
// cvsq_select
// Third stage: pick the note index and the octave of the chosen note.
// ----------------------------------------------------------------------------
`default_nettype none

module cvsq_select (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid_in,
    input  wire cvsq_pkg::cmp_t    data_in,
    output logic                   up_ready,
    input  wire logic              down_ready,
    output logic                   valid_out,
    output cvsq_pkg::sel_t         data_out
);
    import cvsq_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    sel_t             data_reg;
    sel_t             data_next;
    logic             found;
    logic [IDX_W-1:0] first_hit;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        found     = 1'b0;
        first_hit = '0;
        // lowest pair wins
        for (int i = PAIRS - 1; i >= 0; i--)
        begin
            if (data_in.hit[i])
            begin
                found     = 1'b1;
                first_hit = IDX_W'(i);
            end
        end
        data_next.raw  = data_in.raw;
        data_next.pass = data_in.pass;
        data_next.oct  = data_in.oct;
        data_next.idx  = '0;
        if (data_in.pass)
        begin
            data_next.idx = '0;
        end
        else if (found)
        begin
            data_next.idx = data_in.up[first_hit] ? first_hit + 1'b1 : first_hit;
        end
        else if (data_in.below)
        begin
            if (!data_in.prev_first)
            begin
                data_next.idx = data_in.last_idx;
                data_next.oct = data_in.oct - 1'b1;
            end
        end
        else
        begin
            if (data_in.next_first)
            begin
                data_next.oct = data_in.oct + 1'b1;
            end
            else
            begin
                data_next.idx = data_in.last_idx;
            end
        end
        valid_next = up_ready ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

FILE: rtl/cvsq_compose.sv
// ----------------------------------------------------------------------------
// cvsq_compose
// Output stage: octave times volt plus note offset, or the raw sample on pass-through, held until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cvsq_compose (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire cvsq_pkg::notes_t                      notes,
    input  wire logic                                  valid_in,
    input  wire cvsq_pkg::sel_t                        data_in,
    output logic                                       up_ready,
    input  wire logic                                  result_ready,
    output logic                                       result_valid,
    output logic signed [cvsq_pkg::QCV_W-1:0]          quantized_cv,
    output logic signed [cvsq_pkg::OCT_W-1:0]          octave_number,
    output logic        [cvsq_pkg::IDX_W-1:0]          note_number,
    output logic                                       passed_through
);
    import cvsq_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [QCV_W-1:0]  qcv_reg;
    logic [QCV_W-1:0]  qcv_next;
    logic [OCT_W-1:0]  oct_reg;
    logic [IDX_W-1:0]  note_reg;
    logic              pass_reg;
    logic [SUM_W-1:0]  oct_scaled;
    logic [SUM_W-1:0]  note_sum;

    assign up_ready = !valid_reg || result_ready;

    always_comb
    begin
        oct_scaled = {{(SUM_W-OCT_W){data_in.oct[OCT_W-1]}}, data_in.oct}
                     * SUM_W'(UNITS_PER_VOLT);
        note_sum   = oct_scaled + {{(SUM_W-NOTE_W){1'b0}}, notes[data_in.idx]};
        qcv_next   = data_in.pass ? {data_in.raw[RAW_W-1], data_in.raw}
                                  : note_sum[QCV_W-1:0];
        valid_next = up_ready ? valid_in : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && valid_in)
        begin
            qcv_reg  <= qcv_next;
            oct_reg  <= data_in.oct;
            note_reg <= data_in.idx;
            pass_reg <= data_in.pass;
        end
    end

    assign result_valid   = valid_reg;
    assign quantized_cv   = qcv_reg;
    assign octave_number  = oct_reg;
    assign note_number    = note_reg;
    assign passed_through = pass_reg;

endmodule

`default_nettype wire

FILE: rtl/cv_scale_quantizer_top.sv
// Pitch CV quantiser: takes one signed CV sample per transaction (1536 units per
// volt) and returns the nearest note of the configured scale, its octave and
// index. One sample is accepted every cycle while result_ready is high; each
// sample is registered in turn by the split, compare, select and compose
// stages before its result is presented. There is one register stage each for
// octave split, parallel note compares, note selection and output compose.
// A stall on the result side holds the pipeline and frees a stage per bubble.
// Write the scale registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
// cv_scale_quantizer_top
// Configuration registers and the four-stage quantiser pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cv_scale_quantizer_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [cvsq_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [cvsq_pkg::WORD_W-1:0]           cfg_data,
    input  wire logic                                  cv_valid,
    output logic                                       cv_ready,
    input  wire logic signed [cvsq_pkg::RAW_W-1:0]     raw_cv,
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output logic signed [cvsq_pkg::QCV_W-1:0]          quantized_cv,
    output logic signed [cvsq_pkg::OCT_W-1:0]          octave_number,
    output logic        [cvsq_pkg::IDX_W-1:0]          note_number,
    output logic                                       passed_through
);
    import cvsq_pkg::*;

    logic [COUNT_W-1:0] note_count_reg;
    logic [COUNT_W-1:0] note_count_next;
    notes_t             notes_reg;
    notes_t             notes_next;

    logic   split_valid;
    logic   split_ready;
    split_t split_data;
    logic   cmp_valid;
    logic   cmp_ready;
    cmp_t   cmp_data;
    logic   sel_valid;
    logic   sel_ready;
    sel_t   sel_data;

    always_comb
    begin
        note_count_next = note_count_reg;
        notes_next      = notes_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_NOTE_COUNT: note_count_next = cfg_data[COUNT_W-1:0];
                REG_NOTES_A:    notes_next[0*NOTES_PER_WORD +: NOTES_PER_WORD] = cfg_data;
                REG_NOTES_B:    notes_next[1*NOTES_PER_WORD +: NOTES_PER_WORD] = cfg_data;
                REG_NOTES_C:    notes_next[2*NOTES_PER_WORD +: NOTES_PER_WORD] = cfg_data;
                REG_NOTES_D:    notes_next[3*NOTES_PER_WORD +: NOTES_PER_WORD] = cfg_data;
                default:        note_count_next = note_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_count_reg <= '0;
            notes_reg      <= '0;
        end
        else
        begin
            note_count_reg <= note_count_next;
            notes_reg      <= notes_next;
        end
    end

    cvsq_split u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (cv_valid),
        .raw_in     (raw_cv),
        .up_ready   (cv_ready),
        .down_ready (split_ready),
        .valid_out  (split_valid),
        .data_out   (split_data)
    );

    cvsq_compare u_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .note_count (note_count_reg),
        .notes      (notes_reg),
        .valid_in   (split_valid),
        .data_in    (split_data),
        .up_ready   (split_ready),
        .down_ready (cmp_ready),
        .valid_out  (cmp_valid),
        .data_out   (cmp_data)
    );

    cvsq_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (cmp_valid),
        .data_in    (cmp_data),
        .up_ready   (cmp_ready),
        .down_ready (sel_ready),
        .valid_out  (sel_valid),
        .data_out   (sel_data)
    );

    cvsq_compose u_compose (
        .clk            (clk),
        .rst_n          (rst_n),
        .notes          (notes_reg),
        .valid_in       (sel_valid),
        .data_in        (sel_data),
        .up_ready       (sel_ready),
        .result_ready   (result_ready),
        .result_valid   (result_valid),
        .quantized_cv   (quantized_cv),
        .octave_number  (octave_number),
        .note_number    (note_number),
        .passed_through (passed_through)
    );

endmodule

`default_nettype wire

FILE: rtl/cvsq_checker.sv
// ----------------------------------------------------------------------------
// cvsq_checker
// Port-level checks of the CV quantiser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cv_scale_quantizer_top_macros.svh"

module cvsq_checker (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cv_ready,
    input  wire logic                                  result_valid,
    input  wire logic                                  result_ready,
    input  wire logic signed [cvsq_pkg::QCV_W-1:0]     quantized_cv,
    input  wire logic        [cvsq_pkg::IDX_W-1:0]     note_number,
    input  wire logic                                  passed_through
);

    `CVSQ_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(quantized_cv) && $stable(note_number) && $stable(passed_through), "result changed while stalled")

    `CVSQ_ASSERT_SAME(a_flow_through, result_ready, cv_ready, "input stalled while output drains")

    `CVSQ_ASSERT_SAME(a_pass_note_zero, result_valid && passed_through, note_number == '0, "note index set on pass-through")

endmodule

bind cv_scale_quantizer_top cvsq_checker u_checker (.*);

`default_nettype wire

FILE: sim/cv_scale_quantizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv_scale_quantizer_top_test
// Drives pitch CV samples through the quantiser and checks every result
// against a local nearest-note model. Scale settings change between traffic
// phases once the pipeline has drained. Both handshakes idle at random, and
// one phase blocks the result side long enough for the input to back up.
// ----------------------------------------------------------------------------

module cv_scale_quantizer_top_test;

    import cvsq_pkg::*;

    localparam int SETTLE_CYCLES        = 12;
    localparam int STUCK_LIMIT          = 1000;
    localparam int RESULT_HOLD_CYCLES   = 150;
    localparam int FIRST_UNMAPPED_INDEX = 5;

    typedef struct packed {
        logic signed [QCV_W-1:0] qcv;
        logic signed [OCT_W-1:0] oct;
        logic        [IDX_W-1:0] idx;
        logic                    pass;
    } pitch_result_t;

    logic                           clk            = 1'b0;
    logic                           rst_n          = 1'b0;
    logic                           cfg_write      = 1'b0;
    logic        [CFG_INDEX_W-1:0]  cfg_index      = '0;
    logic        [WORD_W-1:0]       cfg_data       = '0;
    logic                           cv_valid       = 1'b0;
    logic                           cv_ready;
    logic signed [RAW_W-1:0]        raw_cv         = '0;
    logic                           result_valid;
    logic                           result_ready   = 1'b0;
    logic signed [QCV_W-1:0]        quantized_cv;
    logic signed [OCT_W-1:0]        octave_number;
    logic        [IDX_W-1:0]        note_number;
    logic                           passed_through;

    logic signed [RAW_W-1:0] pending_cv[$];
    pitch_result_t           pitch_expected[$];

    logic [COUNT_W-1:0] scale_count = '0;
    logic [WORD_W-1:0]  scale_words[MAX_NOTES / NOTES_PER_WORD];
    int                 scale_plan[MAX_NOTES];

    int mismatch_count = 0;
    int send_wait      = 0;
    bit send_quiet     = 1'b0;
    int recv_wait      = 0;
    bit recv_quiet     = 1'b0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit hold_results   = 1'b0;
    bit burst_mode     = 1'b0;
    int stuck_cycles   = 0;

    cv_scale_quantizer_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cv_valid       (cv_valid),
        .cv_ready       (cv_ready),
        .raw_cv         (raw_cv),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .quantized_cv   (quantized_cv),
        .octave_number  (octave_number),
        .note_number    (note_number),
        .passed_through (passed_through)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int note_offset(input int i);
        return int'(scale_words[i >> 2][(i & 3) * NOTE_W +: NOTE_W]);
    endfunction

    function automatic pitch_result_t snap_to_scale(input logic signed [RAW_W-1:0] raw);
        int            cv;
        int            oct;
        int            frac;
        int            n;
        int            offset;
        int            out_oct;
        int            pick;
        int            lo;
        int            hi;
        int            first;
        int            last;
        int            k;
        bit            found;
        pitch_result_t r;
        cv = raw;
        if (cv >= 0)
            oct = cv / UNITS_PER_VOLT;
        else
            oct = -((-cv + UNITS_PER_VOLT - 1) / UNITS_PER_VOLT);
        frac = cv - oct * UNITS_PER_VOLT;
        n = scale_count;
        if (n > MAX_NOTES)
            n = MAX_NOTES;
        if (n == 0)
        begin
            r.qcv  = QCV_W'(cv);
            r.oct  = OCT_W'(oct);
            r.idx  = '0;
            r.pass = 1'b1;
            return r;
        end
        found   = 1'b0;
        offset  = 0;
        pick    = 0;
        out_oct = oct;
        for (k = 0; k + 1 < n && !found; k++)
        begin
            lo = note_offset(k);
            hi = note_offset(k + 1);
            if (frac >= lo && frac <= hi)
            begin
                found = 1'b1;
                if (hi - frac < frac - lo)
                begin
                    offset = hi;
                    pick   = k + 1;
                end
                else
                begin
                    offset = lo;
                    pick   = k;
                end
            end
        end
        if (!found)
        begin
            first = note_offset(0);
            last  = note_offset(n - 1);
            if (frac < first)
            begin
                if (first - frac < frac - (last - UNITS_PER_VOLT))
                begin
                    offset = first;
                    pick   = 0;
                end
                else
                begin
                    offset  = last;
                    pick    = n - 1;
                    out_oct = oct - 1;
                end
            end
            else
            begin
                if (first + UNITS_PER_VOLT - frac < frac - last)
                begin
                    offset  = first;
                    pick    = 0;
                    out_oct = oct + 1;
                end
                else
                begin
                    offset = last;
                    pick   = n - 1;
                end
            end
        end
        r.qcv  = QCV_W'(out_oct * UNITS_PER_VOLT + offset);
        r.oct  = OCT_W'(out_oct);
        r.idx  = IDX_W'(pick);
        r.pass = 1'b0;
        return r;
    endfunction

    // Sender: present queued samples, idling between transactions
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            cv_valid <= 1'b0;
            raw_cv   <= '0;
            send_wait = 0;
        end
        else if (cv_valid && cv_ready)
        begin
            pitch_expected.push_back(snap_to_scale(raw_cv));
            if ($urandom_range(0, 31) == 0)
                send_quiet = !send_quiet;
            gap = (send_quiet || burst_mode) ? 0 : $urandom_range(0, 17);
            if (gap == 0 && pending_cv.size() != 0)
                raw_cv <= pending_cv.pop_front();
            else
            begin
                cv_valid <= 1'b0;
                send_wait = (gap > 0) ? gap - 1 : 0;
            end
        end
        else if (!cv_valid)
        begin
            if (send_wait > 0)
                send_wait--;
            else if (pending_cv.size() != 0)
            begin
                cv_valid <= 1'b1;
                raw_cv   <= pending_cv.pop_front();
            end
        end
    end

    // Receiver: check each result transaction, then stall at random
    always @(posedge clk or negedge rst_n)
    begin
        pitch_result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (pitch_expected.size() == 0)
                begin
                    $error("result with no sample outstanding: quantized_cv %0d",
                           quantized_cv);
                    mismatch_count++;
                end
                else
                begin
                    want = pitch_expected.pop_front();
                    if (quantized_cv !== want.qcv)
                    begin
                        $error("quantized_cv expected %0d actual %0d",
                               $signed(want.qcv), quantized_cv);
                        mismatch_count++;
                    end
                    if (octave_number !== want.oct)
                    begin
                        $error("octave_number expected %0d actual %0d",
                               $signed(want.oct), octave_number);
                        mismatch_count++;
                    end
                    if (note_number !== want.idx)
                    begin
                        $error("note_number expected %0d actual %0d",
                               want.idx, note_number);
                        mismatch_count++;
                    end
                    if (passed_through !== want.pass)
                    begin
                        $error("passed_through expected %0d actual %0d",
                               want.pass, passed_through);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    recv_quiet = !recv_quiet;
                recv_wait = recv_quiet ? 0 : $urandom_range(0, 17);
            end
            if (hold_results && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = RESULT_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((cv_valid && cv_ready) || (result_valid && result_ready) ||
            (pending_cv.size() == 0 && !cv_valid && pitch_expected.size() == 0))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("cv_scale_quantizer_top verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [WORD_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (index)
            REG_NOTE_COUNT: scale_count    = data[COUNT_W-1:0];
            REG_NOTES_A:    scale_words[0] = data;
            REG_NOTES_B:    scale_words[1] = data;
            REG_NOTES_C:    scale_words[2] = data;
            REG_NOTES_D:    scale_words[3] = data;
            default:        ;
        endcase
    endtask

    task automatic program_scale(input int count);
        logic [WORD_W-1:0] word;
        int                w;
        int                k;
        for (w = 0; w < MAX_NOTES / NOTES_PER_WORD; w++)
        begin
            for (k = 0; k < NOTES_PER_WORD; k++)
                word[k * NOTE_W +: NOTE_W] = NOTE_W'(scale_plan[w * NOTES_PER_WORD + k]);
            write_reg(CFG_INDEX_W'(REG_NOTES_A + w), word);
        end
        word = {$urandom, $urandom};
        word[COUNT_W-1:0] = COUNT_W'(count);
        write_reg(REG_NOTE_COUNT, word);
    endtask

    task automatic scramble_plan();
        int k;
        for (k = 0; k < MAX_NOTES; k++)
            scale_plan[k] = $urandom_range(0, 65535);
    endtask

    task automatic ascending_plan(input int count);
        int k;
        int cur;
        scramble_plan();
        cur = $urandom_range(0, 300);
        for (k = 0; k < count; k++)
        begin
            scale_plan[k] = cur;
            cur += $urandom_range(0, (UNITS_PER_VOLT - 1 - cur) / (count - k));
        end
    endtask

    task automatic wait_idle();
        while (pending_cv.size() != 0 || cv_valid || pitch_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_cv(input int v);
        pending_cv.push_back(RAW_W'(v));
    endtask

    task automatic queue_random_cv(input int count);
        int j;
        int n;
        int k;
        int frac;
        int oct;
        for (j = 0; j < count; j++)
        begin
            n = (scale_count > MAX_NOTES) ? MAX_NOTES : scale_count;
            if (n == 0 || $urandom_range(0, 2) == 0)
                queue_cv($urandom_range(0, 32767));
            else
            begin
                k    = $urandom_range(0, n - 1);
                frac = note_offset(k);
                case ($urandom_range(0, 2))
                    0: frac = frac + $urandom_range(0, 4) - 2;
                    1: frac = (frac + ((k + 1 < n) ? note_offset(k + 1)
                                       : note_offset(0) + UNITS_PER_VOLT)) / 2;
                    default: frac = (frac + ((k > 0) ? note_offset(k - 1)
                                             : note_offset(n - 1) - UNITS_PER_VOLT)) / 2;
                endcase
                oct = $urandom_range(0, 19);
                oct = oct - 10;
                queue_cv(oct * UNITS_PER_VOLT + frac);
            end
        end
    endtask

    initial
    begin
        int k;
        for (k = 0; k < MAX_NOTES / NOTES_PER_WORD; k++)
            scale_words[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through straight out of reset
        queue_cv(-16384);
        queue_cv(16383);
        queue_cv(0);
        queue_cv(-1);
        queue_cv(-1536);
        queue_cv(1535);
        queue_random_cv(80);
        wait_idle();

        // Equal twelve-step scale: ties inside and above the last note
        scramble_plan();
        for (k = 0; k < 12; k++)
            scale_plan[k] = k * 128;
        program_scale(12);
        queue_cv(64);
        queue_cv(65);
        queue_cv(1472);
        queue_cv(1473);
        queue_cv(-1);
        queue_random_cv(90);
        wait_idle();

        // First note well above zero: fraction below the first note
        scramble_plan();
        scale_plan[0] = 800;
        scale_plan[1] = 1000;
        scale_plan[2] = 1200;
        program_scale(3);
        queue_cv(232);
        queue_cv(233);
        queue_cv(0);
        queue_cv(900);
        queue_cv(1535);
        queue_cv(-16384);
        queue_random_cv(90);
        wait_idle();

        // Single note
        scramble_plan();
        scale_plan[0] = 700;
        program_scale(1);
        queue_cv(1468);
        queue_cv(-68);
        queue_random_cv(80);
        wait_idle();

        // Full scale; block results while samples keep coming
        ascending_plan(MAX_NOTES);
        program_scale(MAX_NOTES);
        burst_mode   = 1'b1;
        hold_results = 1'b1;
        queue_random_cv(200);
        wait_idle();
        burst_mode = 1'b0;

        // Oversized count with unordered, oversized notes; sender pauses midway
        scramble_plan();
        program_scale((1 << COUNT_W) - 1);
        queue_random_cv(50);
        wait_idle();
        queue_random_cv(50);
        wait_idle();

        // All notes at the top code
        for (k = 0; k < MAX_NOTES; k++)
            scale_plan[k] = (1 << NOTE_W) - 1;
        program_scale(MAX_NOTES);
        queue_cv(16383);
        queue_cv(-16384);
        queue_cv(0);
        queue_random_cv(60);
        wait_idle();

        // Writes to unmapped indexes must leave the scale alone
        ascending_plan(7);
        program_scale(7);
        for (k = FIRST_UNMAPPED_INDEX; k < (1 << CFG_INDEX_W); k++)
            write_reg(CFG_INDEX_W'(k), {$urandom, $urandom});
        queue_random_cv(80);
        wait_idle();

        // Back to pass-through with notes still loaded
        ascending_plan(MAX_NOTES);
        program_scale(0);
        queue_cv(-7680);
        queue_cv(15359);
        queue_random_cv(80);
        wait_idle();

        if (mismatch_count == 0 && pitch_expected.size() == 0)
            $display("cv_scale_quantizer_top verification clean");
        else
            $display("cv_scale_quantizer_top verification failed");
        $finish;
    end

endmodule
